// ===== sv/dtc_pkg.sv =====
package dtc_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int TABLE_LOG2 = $clog2(TABLE_SIZE);

    localparam int IDX_W   = 10;
    localparam int GAIN_W  = 16;
    localparam int VOLT_W  = 16;
    localparam int MAG_W   = 17;
    localparam int DIFF_W  = 17;
    localparam int LDIFF_W = MAG_W + 1;
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int SQ_W      = 2 * VOLT_W;
    localparam int LPROD_W   = GAIN_W + LDIFF_W;
    localparam int LVAL_W    = LPROD_W - 9 + 1;
    localparam int DIV_NUM_W = GAIN_W + 2 * VOLT_W + 1;
    localparam int DIV_DEN_W = VOLT_W + 9;
    localparam int QUO_W     = OUT_W;

    localparam logic [MAG_W-1:0] V_MAX   = {MAG_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd256;
    localparam logic [VOLT_W-1:0] BIAS_RESET   = 16'd13107;
    localparam logic [VOLT_W-1:0] LINEAR_RESET = 16'd26214;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 2'd2;

    typedef enum logic [1:0] {
        REGION_DEAD,
        REGION_QUAD,
        REGION_LIN
    } dtc_region_t;

    typedef struct packed {
        logic             valid;
        logic             use_quot;
        logic [OUT_W-1:0] alt_value;
        logic             alt_sat;
    } dtc_side_t;

endpackage

// ===== sv/dtc_div.sv =====
module dtc_div
    import dtc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    input  dtc_side_t            side_in,
    output logic [QUO_W-1:0]     quotient,
    output dtc_side_t            side_out
);

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - k;

        logic [DIV_NUM_W-1:0] rem_cur;
        logic [QUO_W-1:0]     quo_cur;
        dtc_side_t            side_cur;
        logic [DIV_NUM_W-1:0] shifted;
        logic [DIV_NUM_W:0]   trial;
        logic [QUO_W-1:0]     quo_next;
        logic [QUO_W-1:0]     quo_reg;
        dtc_side_t            side_reg;

        if (k == 0)
        begin : g_first
            assign rem_cur  = dividend;
            assign quo_cur  = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign rem_cur  = g_step[k-1].g_rem.rem_reg;
            assign quo_cur  = g_step[k-1].quo_reg;
            assign side_cur = g_step[k-1].side_reg;
        end

        assign shifted = DIV_NUM_W'(divisor) << BIT;
        assign trial   = {1'b0, rem_cur} - {1'b0, shifted};

        always_comb
        begin
            quo_next      = quo_cur;
            quo_next[BIT] = ~trial[DIV_NUM_W];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg <= '0;
            end
            else
            begin
                side_reg <= side_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            quo_reg <= quo_next;
        end

        if (k < QUO_W - 1)
        begin : g_rem
            logic [DIV_NUM_W-1:0] rem_reg;

            always_ff @(posedge clk)
            begin
                rem_reg <= trial[DIV_NUM_W] ? rem_cur : trial[DIV_NUM_W-1:0];
            end
        end
    end

    assign quotient = g_step[QUO_W-1].quo_reg;
    assign side_out = g_step[QUO_W-1].side_reg;

endmodule

// ===== sv/diode_transfer_curve.sv =====
// The 29 register stages are four arithmetic stages, one restoring divider stage per quotient
// bit and an output register.
// Throughput: one item per cycle; busy stays low, as nothing in the pipeline can stall.
// Each result is shown for a single cycle with done high; the receiver cannot stall.
// Reset clears all valid bits and loads the default gain and voltages.
module diode_transfer_curve
    import dtc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [IDX_W-1:0]     curve_index,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic [OUT_W-1:0]     curve_value,
    output logic                 saturated
);

    logic [GAIN_W-1:0] gain_reg;
    logic [VOLT_W-1:0] bias_reg;
    logic [VOLT_W-1:0] linear_reg;
    logic [VOLT_W-1:0] width_q;
    logic              accept;

    logic [DIFF_W-1:0]        twice_idx;
    logic [DIFF_W-1:0]        diff;
    logic [DIFF_W+15:0]       mag_wide;
    logic [MAG_W-1:0]         v_next;
    logic                     s1_valid_reg;
    logic [MAG_W-1:0]         s1_v_reg;

    dtc_region_t              region_next;
    logic [LDIFF_W-1:0]       ldiff_next;
    logic                     s2_valid_reg;
    dtc_region_t              s2_region_reg;
    logic [VOLT_W-1:0]        s2_d_reg;
    logic [LDIFF_W-1:0]       s2_ldiff_reg;

    logic                     s3_valid_reg;
    dtc_region_t              s3_region_reg;
    logic [SQ_W-1:0]          s3_sq_reg;
    logic [LPROD_W-1:0]       s3_lprod_reg;

    logic [LVAL_W-1:0]        lval;
    dtc_side_t                side_next;
    dtc_side_t                s4_side_reg;
    logic [DIV_NUM_W-1:0]     s4_num_reg;

    logic [QUO_W-1:0]         quotient;
    dtc_side_t                div_side;

    logic                     done_reg;
    logic [OUT_W-1:0]         value_reg;
    logic                     sat_reg;

    assign busy    = 1'b0;
    assign accept  = start & ~busy;
    assign width_q = linear_reg - bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_RESET;
            bias_reg   <= BIAS_RESET;
            linear_reg <= LINEAR_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_data;
                REG_BIAS:   bias_reg   <= cfg_data;
                REG_LINEAR: linear_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Magnitude |2i - N| / N in Q1.16.
    always_comb
    begin
        twice_idx = DIFF_W'({curve_index, 1'b0});
        if (twice_idx >= DIFF_W'(TABLE_SIZE))
        begin
            diff = twice_idx - DIFF_W'(TABLE_SIZE);
        end
        else
        begin
            diff = DIFF_W'(TABLE_SIZE) - twice_idx;
        end
        mag_wide = {diff, 16'b0} >> TABLE_LOG2;
        if (mag_wide > (DIFF_W+16)'(V_MAX))
        begin
            v_next = V_MAX;
        end
        else
        begin
            v_next = mag_wide[MAG_W-1:0];
        end
    end

    always_comb
    begin
        if (s1_v_reg <= MAG_W'(bias_reg))
        begin
            region_next = REGION_DEAD;
        end
        else if (s1_v_reg <= MAG_W'(linear_reg))
        begin
            region_next = REGION_QUAD;
        end
        else
        begin
            region_next = REGION_LIN;
        end
        ldiff_next = {s1_v_reg, 1'b0} - LDIFF_W'(linear_reg) - LDIFF_W'(bias_reg);
    end

    always_comb
    begin
        lval = LVAL_W'((s3_lprod_reg + LPROD_W'(256)) >> 9);
        side_next.valid = s3_valid_reg;
        unique case (s3_region_reg)
            REGION_DEAD:
            begin
                side_next.use_quot  = 1'b0;
                side_next.alt_value = '0;
                side_next.alt_sat   = 1'b0;
            end
            REGION_QUAD:
            begin
                side_next.use_quot  = 1'b1;
                side_next.alt_value = '0;
                side_next.alt_sat   = 1'b0;
            end
            REGION_LIN:
            begin
                side_next.use_quot = 1'b0;
                if (lval > LVAL_W'(OUT_MAX))
                begin
                    side_next.alt_value = OUT_MAX;
                    side_next.alt_sat   = 1'b1;
                end
                else
                begin
                    side_next.alt_value = lval[OUT_W-1:0];
                    side_next.alt_sat   = 1'b0;
                end
            end
            default:
            begin
                side_next.use_quot  = 1'b0;
                side_next.alt_value = '0;
                side_next.alt_sat   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_side_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_side_reg  <= side_next;
            done_reg     <= div_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg <= v_next;

        s2_region_reg <= region_next;
        s2_d_reg      <= VOLT_W'(s1_v_reg - MAG_W'(bias_reg));
        s2_ldiff_reg  <= ldiff_next;

        s3_region_reg <= s2_region_reg;
        s3_sq_reg     <= SQ_W'(s2_d_reg) * SQ_W'(s2_d_reg);
        s3_lprod_reg  <= LPROD_W'(gain_reg) * LPROD_W'(s2_ldiff_reg);

        s4_num_reg <= DIV_NUM_W'(gain_reg) * DIV_NUM_W'(s3_sq_reg)
                      + (DIV_NUM_W'(width_q) << 8);

        if (div_side.use_quot)
        begin
            value_reg <= quotient;
            sat_reg   <= 1'b0;
        end
        else
        begin
            value_reg <= div_side.alt_value;
            sat_reg   <= div_side.alt_sat;
        end
    end

    dtc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dividend (s4_num_reg),
        .divisor  ({width_q, 9'b0}),
        .side_in  (s4_side_reg),
        .quotient (quotient),
        .side_out (div_side)
    );

    assign done        = done_reg;
    assign curve_value = value_reg;
    assign saturated   = sat_reg;

endmodule
